@@ rtl/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Key press duration classifier package
// Shared widths, codes and the lane control/result types.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int CMD_W     = 2;
    localparam int LEVELS_W  = 16;
    localparam int DT_W      = 8;
    localparam int KEY_IDX_W = 4;
    localparam int TIMER_W   = 16;
    localparam int CODE_W    = 3;
    localparam int FLAGS_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMER_W-1:0] SHORT_TIME_RST = 16'd20;
    localparam logic [TIMER_W-1:0] LONG_TIME_RST  = 16'd1000;
    localparam logic [LEVELS_W-1:0] LONG_MODE_RST = '0;

    // flag bit positions
    localparam int FLAG_FIRST      = 0;
    localparam int FLAG_SHORT_HOLD = 1;
    localparam int FLAG_SHORT_REL  = 2;
    localparam int FLAG_LONG_HOLD  = 3;
    localparam int FLAG_LONG_REL   = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_FIRST      = 3'd1,
        ACT_SHORT_HOLD = 3'd2,
        ACT_SHORT_REL  = 3'd3,
        ACT_LONG_HOLD  = 3'd4,
        ACT_LONG_REL   = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_TIME = 2'd0,
        CFG_LONG_TIME  = 2'd1,
        CFG_LONG_MODE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                tick;
        logic                read;
        logic                check;
        logic                clear;
        logic [DT_W-1:0]     dt;
        logic [TIMER_W-1:0]  short_time;
        logic [TIMER_W-1:0]  long_time;
    } t_lane_ctl;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              has;
    } t_lane_res;

endpackage

@@ rtl/kpd_if.sv @@
// ----------------------------------------------------------------------------
// Key press duration classifier channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface kpd_in_if;
    logic                            valid;
    logic                            ready;
    logic [kpd_pkg::CMD_W-1:0]       cmd;
    logic [kpd_pkg::LEVELS_W-1:0]    key_levels;
    logic [kpd_pkg::DT_W-1:0]        elapsed_ms;
    logic [kpd_pkg::KEY_IDX_W-1:0]   key_index;

    modport source (output valid, cmd, key_levels, elapsed_ms, key_index, input ready);
    modport sink   (input valid, cmd, key_levels, elapsed_ms, key_index, output ready);
endinterface

interface kpd_out_if;
    logic                          valid;
    logic                          ready;
    logic [kpd_pkg::CODE_W-1:0]    action_code;
    logic                          has_action;

    modport source (output valid, action_code, has_action, input ready);
    modport sink   (input valid, action_code, has_action, output ready);
endinterface

interface kpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kpd_pkg::CFG_IDX_W-1:0]   index;
    logic [kpd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/key_press_duration_classifier_top.sv @@
// A result item is on the output in the cycle after its input item is accepted
// while the output is free; behind a stalled output it waits in the skid stage.
// Throughput: one item per cycle; every key has its own lane, so a tick updates
// all keys at once and reads, checks and clears touch one lane in the same cycle.
// Input ready drops only while the skid stage holds a result behind a stalled output.
// Reset (synchronous, active low) clears all timers and flags, restores short_time 20,
// long_time 1000 and long_mode_mask 0, and empties the output stage.
// ----------------------------------------------------------------------------
// Key press duration classifier
// Per-key press timing with first press, short/long hold and release flags.
// ----------------------------------------------------------------------------
module key_press_duration_classifier_top #(
    parameter int NUM_KEYS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kpd_in_if.sink    i_in,
    kpd_out_if.source o_out,
    kpd_cfg_if.sink   i_cfg
);
    import kpd_pkg::*;

    // configuration registers: user must write only while block is idle; not enforced
    logic [TIMER_W-1:0]  r_short_time;
    logic [TIMER_W-1:0]  r_long_time;
    logic [LEVELS_W-1:0] r_long_mode;

    logic                         push;
    logic                         in_ready;
    t_lane_ctl                    ctl;
    t_lane_res [NUM_KEYS-1:0]     lane_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_time <= SHORT_TIME_RST;
            r_long_time  <= LONG_TIME_RST;
            r_long_mode  <= LONG_MODE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SHORT_TIME: r_short_time <= i_cfg.data;
                CFG_LONG_TIME:  r_long_time  <= i_cfg.data;
                CFG_LONG_MODE:  r_long_mode  <= i_cfg.data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // decode the accepted item into strobes shared by all lanes
    assign i_in.ready = in_ready;
    assign push       = i_in.valid && in_ready;

    always_comb begin
        ctl.tick       = push && (t_cmd'(i_in.cmd) == CMD_TICK);
        ctl.read       = push && (t_cmd'(i_in.cmd) == CMD_READ);
        ctl.check      = push && (t_cmd'(i_in.cmd) == CMD_CHECK);
        ctl.clear      = push && (t_cmd'(i_in.cmd) == CMD_CLEAR);
        ctl.dt         = i_in.elapsed_ms;
        ctl.short_time = r_short_time;
        ctl.long_time  = r_long_time;
    end

    // one lane per key; keys past the level field see released and short mode,
    // and cannot be addressed by the key index
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic sel;
        logic on;
        logic lmode;

        if (k < LEVELS_W) begin : g_mapped
            assign sel   = ({1'b0, i_in.key_index} == (KEY_IDX_W + 1)'(k));
            assign on    = i_in.key_levels[k];
            assign lmode = r_long_mode[k];
        end else begin : g_unmapped
            assign sel   = 1'b0;
            assign on    = 1'b0;
            assign lmode = 1'b0;
        end

        kpd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_sel       (sel),
            .i_on        (on),
            .i_long_mode (lmode),
            .o_res       (lane_res[k])
        );
    end

    // merge lane results and buffer them toward the output
    kpd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (lane_res),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    // an accepted item always leaves a result waiting on the next cycle
    a_push_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("accepted item produced no result");

    // input backs up only behind a waiting result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty output");

    // result code stays within the defined actions
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.action_code <= ACT_LONG_REL))
        else $error("undefined action code");
`endif

endmodule

@@ rtl/kpd_lane.sv @@
// ----------------------------------------------------------------------------
// Key press duration classifier lane
// Press timer and action flags of one key, with tick, read and clear logic.
// ----------------------------------------------------------------------------
module kpd_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kpd_pkg::t_lane_ctl i_ctl,
    input  logic               i_sel,
    input  logic               i_on,
    input  logic               i_long_mode,
    output kpd_pkg::t_lane_res o_res
);
    import kpd_pkg::*;

    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [FLAGS_W-1:0] r_flags, n_flags;
    logic [FLAGS_W-1:0] rd_flags;
    t_action            rd_code;
    logic [TIMER_W:0]   sum;
    logic [TIMER_W-1:0] sat;

    assign sum = {1'b0, r_timer} + {{(TIMER_W + 1 - DT_W){1'b0}}, i_ctl.dt};
    assign sat = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];

    // pick the highest-priority pending action and drop the flags it consumes
    always_comb begin
        rd_flags = r_flags;
        rd_code  = ACT_NONE;
        priority if (r_flags[FLAG_FIRST]) begin
            rd_code = ACT_FIRST;
            rd_flags[FLAG_FIRST] = 1'b0;
        end else if (r_flags[FLAG_SHORT_HOLD]) begin
            rd_code = ACT_SHORT_HOLD;
            if (r_flags[FLAG_SHORT_REL] || r_flags[FLAG_LONG_REL] || r_flags[FLAG_LONG_HOLD]) begin
                rd_flags[FLAG_SHORT_HOLD] = 1'b0;
            end
        end else if (r_flags[FLAG_LONG_HOLD]) begin
            rd_code = ACT_LONG_HOLD;
            if (r_flags[FLAG_SHORT_REL] || r_flags[FLAG_LONG_REL]) begin
                rd_flags[FLAG_LONG_HOLD] = 1'b0;
            end
        end else if (r_flags[FLAG_SHORT_REL] || r_flags[FLAG_LONG_REL]) begin
            rd_code  = r_flags[FLAG_SHORT_REL] ? ACT_SHORT_REL : ACT_LONG_REL;
            rd_flags = '0;
        end else begin
            rd_code = ACT_NONE;
        end
    end

    always_comb begin
        n_timer = r_timer;
        n_flags = r_flags;
        if (i_ctl.tick) begin
            priority if (r_timer < i_ctl.short_time) begin
                n_timer = i_on ? sat : '0;
            end else if (r_flags == '0) begin
                n_flags[FLAG_FIRST]      = 1'b1;
                n_flags[FLAG_SHORT_HOLD] = 1'b1;
            end else if (!i_long_mode) begin
                if (i_on) begin
                    n_flags[FLAG_SHORT_HOLD] = 1'b1;
                end else begin
                    n_timer = '0;
                    n_flags[FLAG_SHORT_REL] = 1'b1;
                end
            end else if (r_timer < i_ctl.long_time) begin
                if (i_on) begin
                    n_timer = sat;
                end else begin
                    n_timer = '0;
                    n_flags[FLAG_SHORT_REL] = 1'b1;
                end
            end else begin
                if (i_on) begin
                    n_flags[FLAG_LONG_HOLD] = 1'b1;
                end else begin
                    n_timer = '0;
                    n_flags[FLAG_LONG_REL] = 1'b1;
                end
            end
        end else if (i_sel && i_ctl.read) begin
            n_flags = rd_flags;
        end else if (i_sel && i_ctl.clear) begin
            n_flags = '0;
            n_timer = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_flags <= '0;
        end else begin
            r_timer <= n_timer;
            r_flags <= n_flags;
        end
    end

    always_comb begin
        o_res.code = ACT_NONE;
        o_res.has  = 1'b0;
        if (i_sel && i_ctl.read) begin
            o_res.code = rd_code;
            o_res.has  = |rd_flags;
        end else if (i_sel && i_ctl.check) begin
            o_res.has  = |r_flags;
        end
    end

endmodule

@@ rtl/kpd_merge.sv @@
// ----------------------------------------------------------------------------
// Key press duration classifier merge
// Combine lane results and hold them in an output register with a skid stage.
// ----------------------------------------------------------------------------
module kpd_merge #(
    parameter int NUM_KEYS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  kpd_pkg::t_lane_res [NUM_KEYS-1:0]  i_res,
    output logic                               o_in_ready,
    kpd_out_if.source                          o_out
);
    import kpd_pkg::*;

    t_lane_res merged;
    t_lane_res r_out, n_out;
    t_lane_res r_skid, n_skid;
    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    logic      pop;

    // at most one lane drives a nonzero result
    always_comb begin
        merged = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            merged.code = merged.code | i_res[k].code;
            merged.has  = merged.has  | i_res[k].has;
        end
    end

    assign pop        = r_out_valid && o_out.ready;
    assign o_in_ready = !r_skid_valid;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out       = merged;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = merged;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action_code = r_out.code;
    assign o_out.has_action  = r_out.has;

endmodule
